// ----- rtl/tvif_pkg.sv -----
// ---------------------------------------------------------------------------
// tvif_pkg: shared definitions for the time-varying IIR filter
// Request codes, field widths and parameter defaults used by the filter
// and its port checker.
// ---------------------------------------------------------------------------
package tvif_pkg;

  // Parameter defaults
  localparam int DEF_CHANNELS = 4;
  localparam int DEF_NUM_TAPS = 8;
  localparam int DEF_DEN_TAPS = 8;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int CHANNEL_W = 2;
  localparam int TAP_W     = 3;
  localparam int COEFF_W   = 18;
  localparam int SAMPLE_W  = 16;

  // Width of one multiplier digit taken from the sample per cycle
  localparam int DIGIT_W   = 4;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_NUM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_DEN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FILTER   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;

  // Output limits in Q1.15
  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

endpackage

// ----- rtl/time_varying_iir_filter.sv -----
// ---------------------------------------------------------------------------
// time_varying_iir_filter: multichannel direct-form I IIR filter
// Coefficients are loaded tap by tap and may change between samples. Each
// sample request is filtered with a digit-serial multiply-accumulate and a
// bit-serial restoring divider, and the saturated result is emitted.
// ---------------------------------------------------------------------------
// Usage
// The input channel (in_valid / in_stall) carries three kinds of request:
// numerator tap loads, denominator tap loads and samples to filter. A load
// gives no result. A sample for a valid channel gives exactly one result
// on the output channel (out_valid / out_stall). A new sample is taken
// only after the previous one's result has entered the output register.
// The accumulator is ACC_W = 34 + clog2(NUM_TAPS + DEN_TAPS) bits wide.
// Each sample is filtered by the single 18x4 bit multiplier, which takes
// one 4-bit digit of the sample per cycle after a memory read for each
// tap, and by the divider that produces one quotient bit per cycle. Loads
// are taken back to back while the block is idle.
// After reset the block sweeps the sample histories to zero, one entry per
// cycle over max(CHANNELS*NUM_TAPS, CHANNELS*DEN_TAPS) addresses (32 by
// default), holding in_stall high. A finished result waits in the output
// register while out_stall is high; the next sample may already be taken,
// and it holds in its last step until the output register is free.
// ---------------------------------------------------------------------------
module time_varying_iir_filter #(
  parameter int CHANNELS = tvif_pkg::DEF_CHANNELS,
  parameter int NUM_TAPS = tvif_pkg::DEF_NUM_TAPS,
  parameter int DEN_TAPS = tvif_pkg::DEF_DEN_TAPS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [tvif_pkg::FUNC_W-1:0]           in_func,
  input  logic [tvif_pkg::CHANNEL_W-1:0]        in_channel,
  input  logic [tvif_pkg::TAP_W-1:0]            in_tap,
  input  logic signed [tvif_pkg::COEFF_W-1:0]   in_coeff,
  input  logic signed [tvif_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_frame_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tvif_pkg::CHANNEL_W-1:0]        out_channel,
  output logic signed [tvif_pkg::SAMPLE_W-1:0]  out_result,
  output logic                                  out_divide_error,
  output logic                                  out_saturated
);
  import tvif_pkg::*;

  // Derived sizes
  localparam int IH_DEPTH  = CHANNELS * NUM_TAPS;
  localparam int OH_DEPTH  = CHANNELS * DEN_TAPS;
  localparam int CLR_DEPTH = (IH_DEPTH > OH_DEPTH) ? IH_DEPTH : OH_DEPTH;
  localparam int IA_W  = (IH_DEPTH > 1) ? $clog2(IH_DEPTH) : 1;
  localparam int OA_W  = (OH_DEPTH > 1) ? $clog2(OH_DEPTH) : 1;
  localparam int CLR_W = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int IP_W  = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int OP_W  = (DEN_TAPS > 1) ? $clog2(DEN_TAPS) : 1;
  localparam int MAXT  = (NUM_TAPS > DEN_TAPS) ? NUM_TAPS : DEN_TAPS;
  localparam int K_W   = (MAXT > 1) ? $clog2(MAXT) : 1;
  localparam int ACC_W = 34 + $clog2(NUM_TAPS + DEN_TAPS);
  localparam int DIGITS = SAMPLE_W / DIGIT_W;
  localparam int DG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int DC_W  = $clog2(ACC_W + 1);
  localparam int PP_W  = COEFF_W + DIGIT_W + 1;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_A0    = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DPREP = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  // Memories
  logic signed [SAMPLE_W-1:0] ih_mem [IH_DEPTH];
  logic signed [SAMPLE_W-1:0] oh_mem [OH_DEPTH];
  logic signed [COEFF_W-1:0]  num_mem [IH_DEPTH];
  logic signed [COEFF_W-1:0]  den_mem [OH_DEPTH];

  logic signed [SAMPLE_W-1:0] ih_q_r, oh_q_r;
  logic signed [COEFF_W-1:0]  num_q_r, den_q_r;

  // Control and datapath registers
  logic [2:0]                state_r, state_nxt;
  logic [CLR_W-1:0]          clr_r;
  logic [IP_W-1:0]           iptr_r;
  logic [OP_W-1:0]           optr_r;
  logic [CHANNEL_W-1:0]      ch_r;
  logic                      fend_r;
  logic [K_W-1:0]            k_r;
  logic                      den_r;
  logic [DG_W-1:0]           dig_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [COEFF_W-1:0] a0_r;
  logic                      neg_r;
  logic [COEFF_W-1:0]        dmag_r;
  logic [COEFF_W-1:0]        rem_r;
  logic [ACC_W-1:0]          quo_r;
  logic [DC_W-1:0]           dcnt_r;
  logic                      out_valid_r;
  logic [CHANNEL_W-1:0]      out_channel_r;
  logic [SAMPLE_W-1:0]       out_result_r;
  logic                      out_derr_r;
  logic                      out_sat_r;

  logic accept;
  logic ch_ok;
  logic out_free;

  assign accept   = in_valid && !in_stall;
  assign ch_ok    = 32'(in_channel) < CHANNELS;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // History and tap read addresses for the current term, and history write addresses
  logic [IA_W-1:0] ih_raddr;
  logic [OA_W-1:0] oh_raddr;
  logic [IA_W-1:0] ih_waddr;
  logic [IA_W-1:0] tap_naddr;
  logic [OA_W-1:0] tap_daddr;
  logic [OA_W-1:0] oh_waddr;
  logic [OA_W-1:0] a0_addr;
  int              ih_idx, oh_idx;

  always_comb begin
    if (int'(iptr_r) >= int'(k_r)) ih_idx = int'(iptr_r) - int'(k_r);
    else ih_idx = int'(iptr_r) + NUM_TAPS - int'(k_r);
    if (int'(optr_r) >= int'(k_r)) oh_idx = int'(optr_r) - int'(k_r);
    else oh_idx = int'(optr_r) + DEN_TAPS - int'(k_r);
    ih_raddr  = IA_W'(int'(ch_r) * NUM_TAPS + ih_idx);
    oh_raddr  = OA_W'(int'(ch_r) * DEN_TAPS + oh_idx);
    tap_naddr = IA_W'(int'(ch_r) * NUM_TAPS + int'(k_r));
    tap_daddr = OA_W'(int'(ch_r) * DEN_TAPS + int'(k_r));
    a0_addr   = OA_W'(int'(ch_r) * DEN_TAPS);
    ih_waddr  = IA_W'(int'(in_channel) * NUM_TAPS + int'(iptr_r));
    oh_waddr  = OA_W'(int'(ch_r) * DEN_TAPS + int'(optr_r));
  end

  // Partial product of the coefficient and one sample digit
  logic signed [COEFF_W-1:0]  mcand;
  logic signed [SAMPLE_W-1:0] mplier;
  logic [DIGIT_W-1:0]         digit;
  logic signed [DIGIT_W:0]    digit_s;
  logic signed [PP_W-1:0]     pp;
  logic signed [ACC_W-1:0]    pp_sh;
  logic                       last_digit;

  always_comb begin
    mcand      = den_r ? den_q_r : num_q_r;
    mplier     = den_r ? oh_q_r : ih_q_r;
    digit      = mplier[DIGIT_W*dig_r +: DIGIT_W];
    last_digit = (int'(dig_r) == DIGITS - 1);
    digit_s    = last_digit ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
    pp         = PP_W'(mcand) * PP_W'(digit_s);
    pp_sh      = ACC_W'(pp) <<< (DIGIT_W * int'(dig_r));
  end

  // Divider step: one restoring quotient bit per cycle
  logic [COEFF_W:0] trial;
  logic             ge;
  always_comb begin
    trial = {rem_r, quo_r[ACC_W-1]};
    ge    = trial >= {1'b0, dmag_r};
  end

  // Quotient saturation and sign
  logic                upper;
  logic                sat;
  logic [SAMPLE_W-1:0] qval;
  logic [SAMPLE_W-1:0] qlow;
  always_comb begin
    upper = |quo_r[ACC_W-1:SAMPLE_W];
    qlow  = quo_r[SAMPLE_W-1:0];
    if (a0_r == '0) begin
      sat  = 1'b0;
      qval = '0;
    end else if (neg_r) begin
      sat  = upper || (qlow[SAMPLE_W-1] && (|qlow[SAMPLE_W-2:0]));
      qval = sat ? SAT_NEG : (~qlow + 1'b1);
    end else begin
      sat  = upper || qlow[SAMPLE_W-1];
      qval = sat ? SAT_POS : qlow;
    end
  end

  // Next-state logic of the sequencer
  logic term_done;
  always_comb begin
    term_done = den_r ? (int'(k_r) == DEN_TAPS - 1) : (int'(k_r) == NUM_TAPS - 1);
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (int'(clr_r) == CLR_DEPTH - 1) state_nxt = S_IDLE;
      S_IDLE:  if (accept && ch_ok && in_func == FUNC_FILTER) state_nxt = S_A0;
      S_A0:    state_nxt = S_RD;
      S_RD:    state_nxt = S_MUL;
      S_MUL: begin
        if (last_digit) begin
          if (term_done && (den_r || DEN_TAPS == 1)) state_nxt = S_DPREP;
          else state_nxt = S_RD;
        end
      end
      S_DPREP: state_nxt = (a0_r == '0) ? S_FIN : S_DIV;
      S_DIV:   if (int'(dcnt_r) == ACC_W - 1) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      iptr_r      <= '0;
      optr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      // A finished result enters the output register; a taken one leaves it.
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
        if (fend_r) begin
          iptr_r <= (int'(iptr_r) == NUM_TAPS - 1) ? '0 : iptr_r + 1'b1;
          optr_r <= (int'(optr_r) == DEN_TAPS - 1) ? '0 : optr_r + 1'b1;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ch_r   <= in_channel;
        fend_r <= in_frame_end;
        k_r    <= '0;
        den_r  <= 1'b0;
        dig_r  <= '0;
        acc_r  <= '0;
      end
      S_RD: begin
        if (!den_r && k_r == '0) a0_r <= den_q_r;
        dig_r <= '0;
      end
      S_MUL: begin
        acc_r <= den_r ? acc_r - pp_sh : acc_r + pp_sh;
        dig_r <= dig_r + 1'b1;
        if (last_digit) begin
          if (term_done && !den_r) begin
            den_r <= 1'b1;
            k_r   <= K_W'(1);
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
      end
      S_DPREP: begin
        neg_r  <= acc_r[ACC_W-1] ^ a0_r[COEFF_W-1];
        quo_r  <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        dmag_r <= a0_r[COEFF_W-1] ? COEFF_W'(-a0_r) : COEFF_W'(a0_r);
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        rem_r  <= ge ? COEFF_W'(trial - {1'b0, dmag_r}) : trial[COEFF_W-1:0];
        quo_r  <= {quo_r[ACC_W-2:0], ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          out_channel_r <= ch_r;
          out_result_r  <= qval;
          out_derr_r    <= (a0_r == '0);
          out_sat_r     <= sat;
        end
      end
      default: begin
      end
    endcase
  end

  // Input history and numerator taps
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR && 32'(clr_r) < IH_DEPTH) ih_mem[IA_W'(clr_r)] <= '0;
    else if (accept && ch_ok && in_func == FUNC_FILTER) ih_mem[ih_waddr] <= in_sample;
    if (accept && ch_ok && in_func == FUNC_LOAD_NUM && 32'(in_tap) < NUM_TAPS)
      num_mem[IA_W'(int'(in_channel) * NUM_TAPS + int'(in_tap))] <= in_coeff;
    if (state_r == S_RD && !den_r) begin
      ih_q_r  <= ih_mem[ih_raddr];
      num_q_r <= num_mem[tap_naddr];
    end
  end

  // Output history and denominator taps
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR && 32'(clr_r) < OH_DEPTH) oh_mem[OA_W'(clr_r)] <= '0;
    else if (state_r == S_FIN && out_free) oh_mem[oh_waddr] <= qval;
    if (accept && ch_ok && in_func == FUNC_LOAD_DEN && 32'(in_tap) < DEN_TAPS)
      den_mem[OA_W'(int'(in_channel) * DEN_TAPS + int'(in_tap))] <= in_coeff;
    if (state_r == S_A0) begin
      den_q_r <= den_mem[a0_addr];
    end else if (state_r == S_RD && den_r) begin
      oh_q_r  <= oh_mem[oh_raddr];
      den_q_r <= den_mem[tap_daddr];
    end
  end

  // Outputs
  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_result       = out_result_r;
  assign out_divide_error = out_derr_r;
  assign out_saturated    = out_sat_r;

endmodule

// ----- rtl/tvif_chk.sv -----
// ---------------------------------------------------------------------------
// tvif_chk: port checker for the time-varying IIR filter
// Watches the filter's ports and flags results or handshakes that cannot
// come from a correct filter.
// ---------------------------------------------------------------------------
module tvif_chk #(
  parameter int CHANNELS = tvif_pkg::DEF_CHANNELS
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [tvif_pkg::FUNC_W-1:0]          in_func,
  input logic [tvif_pkg::CHANNEL_W-1:0]       in_channel,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [tvif_pkg::CHANNEL_W-1:0]       out_channel,
  input logic signed [tvif_pkg::SAMPLE_W-1:0] out_result,
  input logic                                 out_divide_error,
  input logic                                 out_saturated
);
  import tvif_pkg::*;

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A filter request for a valid channel makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_FILTER && 32'(in_channel) < CHANNELS
    |=> in_stall)
    else $error("block not busy after a filter request");

  // Results only name existing channels.
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_channel) < CHANNELS)
    else $error("result for a channel out of range");

  // A division error yields a plain zero.
  a_derr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_result == '0 && !out_saturated)
    else $error("division error with a non-zero result");

  // A saturated result sits at one of the limits.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_result == SAT_POS || out_result == SAT_NEG)
    else $error("saturated result not at a limit");

endmodule

bind time_varying_iir_filter tvif_chk #(.CHANNELS(CHANNELS)) u_tvif_chk (.*);
